/* design/dri_pkg.sv */
`default_nettype none

package dri_pkg;

  localparam int MAX_DIGITS  = 75;
  localparam int DIGIT_W     = 7;
  localparam int DONE_W      = $clog2(MAX_DIGITS + 3);
  localparam int EXT_W       = 18;
  localparam int SCALE_MAX   = 64;
  localparam int SCALE_W     = $clog2(SCALE_MAX + 1);
  localparam int UNIT_W      = 10;
  localparam int ACC_W       = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    TGT_S32 = 2'd0,
    TGT_U32 = 2'd1,
    TGT_S64 = 2'd2,
    TGT_U64 = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_SCALE,
    BK_DONE
  } back_state_t;

  // one classified unit handed from front to back
  typedef struct packed {
    logic                 first;
    logic                 last;
    logic [1:0]           take;
    logic [UNIT_W-1:0]    q;
    logic [SCALE_W-1:0]   scale;
    logic                 neg;
    logic                 special;
    target_t              target;
  } unit_op_t;

endpackage

`default_nettype wire

/* design/dri_front.sv */
`default_nettype none

module dri_front (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           accept,
  input  wire                           first_unit,
  input  wire  [1:0]                    target_kind,
  input  wire  [6:0]                    digit_count,
  input  wire  signed [15:0]            exponent,
  input  wire                           is_negative,
  input  wire                           is_special,
  input  wire  [9:0]                    unit_value,
  input  wire                           last_unit,
  output dri_pkg::unit_op_t             op
);

  localparam int EW = dri_pkg::EXT_W;
  localparam int DW = dri_pkg::DONE_W;

  logic [1:0]                   saved_target;
  logic [dri_pkg::DIGIT_W-1:0]  saved_digit_count;
  logic [15:0]                  saved_exponent;
  logic                         saved_sign;
  logic                         saved_special;
  logic [DW-1:0]                digits_done;
  logic [DW-1:0]                digits_done_next;

  logic [1:0]                   tgt_eff;
  logic [dri_pkg::DIGIT_W-1:0]  cnt_eff;
  logic [15:0]                  exp_eff;
  logic                         neg_eff;
  logic                         spc_eff;
  logic [DW-1:0]                done_eff;
  logic [dri_pkg::DIGIT_W-1:0]  d;
  logic [dri_pkg::DIGIT_W-1:0]  dm1;
  logic signed [EW-1:0]         int_dig;
  logic signed [EW-1:0]         avail;
  logic signed [EW-1:0]         k_raw;
  logic                         active;
  logic [1:0]                   w;
  logic [1:0]                   take;
  logic [1:0]                   shift;
  logic [DW-1:0]                done_upd;
  logic [17:0]                  prod10;
  logic [15:0]                  prod100;
  logic [dri_pkg::UNIT_W-1:0]   q;
  logic [dri_pkg::SCALE_W-1:0]  scale;

  // x mod 3 from the sum of base-4 digits
  function automatic logic [1:0] mod3(input logic [6:0] x);
    logic [3:0] s;
    s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[6]);
    if (s >= 4'd9)      s = s - 4'd9;
    else if (s >= 4'd6) s = s - 4'd6;
    else if (s >= 4'd3) s = s - 4'd3;
    return s[1:0];
  endfunction

  always_comb begin
    tgt_eff  = first_unit ? target_kind : saved_target;
    cnt_eff  = first_unit ? digit_count : saved_digit_count;
    exp_eff  = first_unit ? exponent    : saved_exponent;
    neg_eff  = first_unit ? is_negative : saved_sign;
    spc_eff  = first_unit ? is_special  : saved_special;
    done_eff = first_unit ? '0          : digits_done;

    if (cnt_eff == '0)
      d = dri_pkg::DIGIT_W'(1);
    else if (cnt_eff > dri_pkg::DIGIT_W'(dri_pkg::MAX_DIGITS))
      d = dri_pkg::DIGIT_W'(dri_pkg::MAX_DIGITS);
    else
      d = cnt_eff;
    dm1 = d - dri_pkg::DIGIT_W'(1);

    int_dig = $signed({{(EW-dri_pkg::DIGIT_W){1'b0}}, d}) +
              $signed({{(EW-16){exp_eff[15]}}, exp_eff});
    avail   = int_dig - $signed({{(EW-DW){1'b0}}, done_eff});
    active  = (int'(done_eff) < int'(d));
    // leading unit may be short
    w = (done_eff == '0) ? (mod3(dm1) + 2'd1) : 2'd3;

    if (!active || avail <= 0)
      take = 2'd0;
    else if (avail > $signed({{(EW-2){1'b0}}, w}))
      take = w;
    else
      take = avail[1:0];

    shift    = w - take;
    done_upd = active ? (done_eff + DW'(w)) : done_eff;

    // unit / 10 and unit / 100 by reciprocal, exact for 10-bit units
    prod10  = 18'(unit_value) * 18'd205;
    prod100 = 16'(unit_value) * 16'd41;
    case (shift)
      2'd0:    q = unit_value;
      2'd1:    q = dri_pkg::UNIT_W'(prod10[17:11]);
      default: q = dri_pkg::UNIT_W'(prod100[15:12]);
    endcase

    k_raw = int_dig - $signed({{(EW-DW){1'b0}}, done_upd});
    if (k_raw <= 0)
      scale = '0;
    else if (k_raw > $signed(EW'(dri_pkg::SCALE_MAX)))
      scale = dri_pkg::SCALE_W'(dri_pkg::SCALE_MAX);
    else
      scale = k_raw[dri_pkg::SCALE_W-1:0];

    digits_done_next = last_unit ? '0 : done_upd;

    op.first   = first_unit;
    op.last    = last_unit;
    op.take    = take;
    op.q       = q;
    op.scale   = scale;
    op.neg     = neg_eff;
    op.special = spc_eff;
    op.target  = dri_pkg::target_t'(tgt_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_target      <= '0;
      saved_digit_count <= '0;
      saved_exponent    <= '0;
      saved_sign        <= 1'b0;
      saved_special     <= 1'b0;
      digits_done       <= '0;
    end else if (accept) begin
      if (first_unit) begin
        saved_target      <= target_kind;
        saved_digit_count <= digit_count;
        saved_exponent    <= exponent;
        saved_sign        <= is_negative;
        saved_special     <= is_special;
      end
      digits_done <= digits_done_next;
    end
  end

endmodule

`default_nettype wire

/* design/dri_queue.sv */
`default_nettype none

module dri_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  wr,
  input  dri_pkg::unit_op_t    wdata,
  input  wire                  rd,
  output dri_pkg::unit_op_t    rdata,
  output logic                 q_empty,
  output logic                 q_full
);

  dri_pkg::unit_op_t               mem [dri_pkg::QUEUE_DEPTH];
  logic [dri_pkg::QPTR_W-1:0]      wptr;
  logic [dri_pkg::QPTR_W-1:0]      rptr;
  logic [dri_pkg::QCNT_W-1:0]      count;
  logic                            do_wr;
  logic                            do_rd;

  assign q_empty = (count == '0);
  assign q_full  = (count == dri_pkg::QCNT_W'(dri_pkg::QUEUE_DEPTH));
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + dri_pkg::QPTR_W'(1);
      if (do_rd) rptr <= rptr + dri_pkg::QPTR_W'(1);
      if (do_wr && !do_rd)
        count <= count + dri_pkg::QCNT_W'(1);
      else if (do_rd && !do_wr)
        count <= count - dri_pkg::QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* design/dri_back.sv */
`default_nettype none

module dri_back (
  input  wire                  clk,
  input  wire                  rst,
  input  dri_pkg::unit_op_t    op,
  input  wire                  q_empty,
  output logic                 q_pop,
  input  wire                  pop,
  output logic                 empty,
  output logic [63:0]          result_bits,
  output logic                 overflow
);

  localparam int AW = dri_pkg::ACC_W;

  dri_pkg::back_state_t          state;
  dri_pkg::back_state_t          state_next;
  logic [AW-1:0]                 accumulator;
  logic [AW-1:0]                 accumulator_next;
  logic                          overflow_seen;
  logic                          overflow_seen_next;
  logic [dri_pkg::SCALE_W-1:0]   scale_cnt;
  logic [dri_pkg::SCALE_W-1:0]   scale_cnt_next;
  logic                          sign;
  logic                          sign_next;
  logic                          special;
  logic                          special_next;
  dri_pkg::target_t              target;
  dri_pkg::target_t              target_next;
  logic                          out_valid;
  logic                          out_load;

  logic [AW-1:0]                 acc_base;
  logic                          ov_base;
  logic [AW+9:0]                 mac;
  logic [AW+3:0]                 times10;
  logic [AW-1:0]                 neg_m;
  logic [AW-1:0]                 pack_bits;
  logic                          pack_ovf;

  always_comb begin
    acc_base = op.first ? '0 : accumulator;
    ov_base  = op.first ? 1'b0 : overflow_seen;
    case (op.take)
      2'd1:    mac = (AW+10)'(acc_base) * (AW+10)'(10);
      2'd2:    mac = (AW+10)'(acc_base) * (AW+10)'(100);
      default: mac = (AW+10)'(acc_base) * (AW+10)'(1000);
    endcase
    mac = mac + (AW+10)'(op.q);
    times10 = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0};
  end

  // truncation to the target width with range check, sign applied; specials give zero
  always_comb begin
    neg_m     = '0 - accumulator;
    pack_bits = '0;
    pack_ovf  = overflow_seen;
    case (target)
      dri_pkg::TGT_S32: begin
        if (sign) begin
          if (accumulator > AW'(64'h8000_0000)) pack_ovf = 1'b1;
          pack_bits = {{32{neg_m[31]}}, neg_m[31:0]};
        end else begin
          if (accumulator > AW'(64'h7FFF_FFFF)) pack_ovf = 1'b1;
          pack_bits = {{32{accumulator[31]}}, accumulator[31:0]};
        end
      end
      dri_pkg::TGT_U32: begin
        if (accumulator[63:32] != '0 || (sign && accumulator != '0)) pack_ovf = 1'b1;
        pack_bits = {32'd0, accumulator[31:0]};
      end
      dri_pkg::TGT_S64: begin
        if (sign) begin
          if (accumulator > 64'h8000_0000_0000_0000) pack_ovf = 1'b1;
          pack_bits = neg_m;
        end else begin
          if (accumulator[63]) pack_ovf = 1'b1;
          pack_bits = accumulator;
        end
      end
      default: begin
        if (sign && accumulator != '0) pack_ovf = 1'b1;
        pack_bits = accumulator;
      end
    endcase
    if (special) begin
      pack_bits = '0;
      pack_ovf  = 1'b0;
    end
  end

  always_comb begin
    state_next         = state;
    accumulator_next   = accumulator;
    overflow_seen_next = overflow_seen;
    scale_cnt_next     = scale_cnt;
    sign_next          = sign;
    special_next       = special;
    target_next        = target;
    q_pop              = 1'b0;
    out_load           = 1'b0;
    unique case (state)
      dri_pkg::BK_RUN: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (op.take != 2'd0) begin
            accumulator_next   = mac[AW-1:0];
            overflow_seen_next = ov_base || (mac[AW+9:AW] != '0);
          end else begin
            accumulator_next   = acc_base;
            overflow_seen_next = ov_base;
          end
          if (op.last) begin
            scale_cnt_next = op.scale;
            sign_next      = op.neg;
            special_next   = op.special;
            target_next    = op.target;
            state_next     = (op.scale != '0) ? dri_pkg::BK_SCALE : dri_pkg::BK_DONE;
          end
        end
      end
      dri_pkg::BK_SCALE: begin
        accumulator_next   = times10[AW-1:0];
        overflow_seen_next = overflow_seen || (times10[AW+3:AW] != '0);
        scale_cnt_next     = scale_cnt - dri_pkg::SCALE_W'(1);
        if (scale_cnt == dri_pkg::SCALE_W'(1)) state_next = dri_pkg::BK_DONE;
      end
      dri_pkg::BK_DONE: begin
        if (!out_valid || pop) begin
          out_load           = 1'b1;
          accumulator_next   = '0;
          overflow_seen_next = 1'b0;
          state_next         = dri_pkg::BK_RUN;
        end
      end
      default: state_next = dri_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dri_pkg::BK_RUN;
      accumulator   <= '0;
      overflow_seen <= 1'b0;
      scale_cnt     <= '0;
      sign          <= 1'b0;
      special       <= 1'b0;
      target        <= dri_pkg::TGT_S32;
    end else begin
      state         <= state_next;
      accumulator   <= accumulator_next;
      overflow_seen <= overflow_seen_next;
      scale_cnt     <= scale_cnt_next;
      sign          <= sign_next;
      special       <= special_next;
      target        <= target_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_bits <= pack_bits;
      overflow    <= pack_ovf;
    end
  end

  assign empty = !out_valid;

  a_pop_only_in_run: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == dri_pkg::BK_RUN && !q_empty))
    else $error("queue read outside run state");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == dri_pkg::BK_SCALE) |-> (scale_cnt != '0))
    else $error("scale loop entered with zero count");

  a_special_zero: assert property (@(posedge clk) disable iff (rst)
    (out_load && special) |=> (result_bits == '0 && !overflow))
    else $error("special value produced nonzero result");

  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (accumulator == '0 && !overflow_seen && state == dri_pkg::BK_RUN))
    else $error("accumulator not cleared after result transfer");

endmodule

`default_nettype wire

/* design/decimal_real_to_integer.sv */
// Channel   Direction  Handshake          Payload
// input     in         push / full        first_unit target_kind digit_count exponent
//                                         is_negative is_special unit_value last_unit
// result    out        empty / pop        result_bits overflow
//
// The back end folds each unit into its multiply-accumulate as it takes it off the queue.
// After the last unit of a number the scaling loop runs k (0..64) x10 steps,
// then the finished result waits to be loaded into the output register.
// Synchronous reset: the unit queue and the output register come up empty.
// full rises when the 4-entry unit queue is full; the back end holds its
// finished result while the output register is still occupied.
`default_nettype none

module decimal_real_to_integer (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  wire                  first_unit,
  input  wire  [1:0]           target_kind,
  input  wire  [6:0]           digit_count,
  input  wire  signed [15:0]   exponent,
  input  wire                  is_negative,
  input  wire                  is_special,
  input  wire  [9:0]           unit_value,
  input  wire                  last_unit,
  output logic                 empty,
  input  wire                  pop,
  output logic [63:0]          result_bits,
  output logic                 overflow
);

  dri_pkg::unit_op_t  front_op;
  dri_pkg::unit_op_t  back_op;
  logic               accept;
  logic               q_empty;
  logic               q_full;
  logic               q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  dri_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .first_unit  (first_unit),
    .target_kind (target_kind),
    .digit_count (digit_count),
    .exponent    (exponent),
    .is_negative (is_negative),
    .is_special  (is_special),
    .unit_value  (unit_value),
    .last_unit   (last_unit),
    .op          (front_op)
  );

  dri_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wdata   (front_op),
    .rd      (q_pop),
    .rdata   (back_op),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  dri_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op          (back_op),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .result_bits (result_bits),
    .overflow    (overflow)
  );

endmodule

`default_nettype wire

/* dv/decimal_real_to_integer_tb.sv */
`timescale 1ns / 100ps

module decimal_real_to_integer_tb;

  typedef struct packed {
    dri_pkg::target_t   tgt;
    logic [6:0]         nd;
    logic signed [15:0] ex;
    logic               neg;
    logic               spec;
  } number_header_t;

  typedef struct packed {
    logic [63:0] bits;
    logic        ovf;
  } int_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               push;
  logic               full;
  logic               first_unit;
  logic [1:0]         target_kind;
  logic [6:0]         digit_count;
  logic signed [15:0] exponent;
  logic               is_negative;
  logic               is_special;
  logic [9:0]         unit_value;
  logic               last_unit;
  logic               empty;
  logic               pop;
  logic [63:0]        result_bits;
  logic               overflow;

  // converter state mirrored by the predictor
  logic [63:0]        conv_acc;
  int                 conv_done;
  logic               conv_ovf;
  dri_pkg::target_t   hdr_target;
  logic [6:0]         hdr_digits;
  logic signed [15:0] hdr_exp;
  logic               hdr_neg;
  logic               hdr_special;

  int_result_t        pending_ints[$];
  int_result_t        head_int;
  logic [9:0]         coef_units[$];

  int  errors = 0;
  int  units_sent = 0;
  int  results_checked = 0;
  int  ovf_results = 0;
  int  full_cycles = 0;
  int  rx_hold_cycles = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  decimal_real_to_integer uut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .first_unit  (first_unit),
    .target_kind (target_kind),
    .digit_count (digit_count),
    .exponent    (exponent),
    .is_negative (is_negative),
    .is_special  (is_special),
    .unit_value  (unit_value),
    .last_unit   (last_unit),
    .empty       (empty),
    .pop         (pop),
    .result_bits (result_bits),
    .overflow    (overflow)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] pow10(input int n);
    case (n)
      0: return 64'd1;
      1: return 64'd10;
      2: return 64'd100;
      default: return 64'd1000;
    endcase
  endfunction

  function automatic int digits_in_use(input logic [6:0] nd);
    int d;
    d = nd;
    if (d < 1) d = 1;
    if (d > dri_pkg::MAX_DIGITS) d = dri_pkg::MAX_DIGITS;
    return d;
  endfunction

  function automatic int int_digit_count();
    return digits_in_use(hdr_digits) + int'(hdr_exp);
  endfunction

  // integer part of one unit: acc = acc * 10^take + leading digits of the unit
  function automatic void accumulate_unit(input logic [9:0] u);
    int d, w, avail, take;
    logic [63:0] q, p;
    d = digits_in_use(hdr_digits);
    if (conv_done >= d) return;
    w = (conv_done == 0) ? ((d - 1) % 3) + 1 : 3;
    avail = int_digit_count() - conv_done;
    take = (avail <= 0) ? 0 : ((avail > w) ? w : avail);
    if (take > 0) begin
      q = 64'(u) / pow10(w - take);
      p = pow10(take);
      if (conv_acc > (64'hFFFF_FFFF_FFFF_FFFF - q) / p) conv_ovf = 1'b1;
      conv_acc = conv_acc * p + q;
    end
    conv_done = (conv_done + w) & 8'hFF;
  endfunction

  function automatic int_result_t finish_integer();
    int_result_t r;
    logic [63:0] m;
    logic [31:0] lo;
    logic ov;
    int k, i;
    r = '0;
    if (hdr_special) return r;
    m = conv_acc;
    ov = conv_ovf;
    k = int_digit_count() - conv_done;
    if (k > 64) k = 64;
    for (i = 0; i < k; i++) begin
      if (m > 64'hFFFF_FFFF_FFFF_FFFF / 10) ov = 1'b1;
      m = m * 10;
    end
    case (hdr_target)
      dri_pkg::TGT_S32: begin
        if (m > (hdr_neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) ov = 1'b1;
        lo = hdr_neg ? (32'd0 - m[31:0]) : m[31:0];
        r.bits = {{32{lo[31]}}, lo};
      end
      dri_pkg::TGT_U32: begin
        if (m > 64'hFFFF_FFFF || (hdr_neg && m != 0)) ov = 1'b1;
        r.bits = {32'd0, m[31:0]};
      end
      dri_pkg::TGT_S64: begin
        if (m > (hdr_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)) ov = 1'b1;
        r.bits = hdr_neg ? (64'd0 - m) : m;
      end
      default: begin
        if (hdr_neg && m != 0) ov = 1'b1;
        r.bits = m;
      end
    endcase
    r.ovf = ov;
    return r;
  endfunction

  function automatic void predict_unit(input logic is_first, input number_header_t h,
                                       input logic [9:0] u, input logic is_last);
    if (is_first) begin
      hdr_target  = h.tgt;
      hdr_digits  = h.nd;
      hdr_exp     = h.ex;
      hdr_neg     = h.neg;
      hdr_special = h.spec;
      conv_acc    = '0;
      conv_done   = 0;
      conv_ovf    = 1'b0;
    end
    accumulate_unit(u);
    if (is_last) begin
      pending_ints.push_back(finish_integer());
      conv_acc  = '0;
      conv_done = 0;
      conv_ovf  = 1'b0;
    end
  endfunction

  function automatic number_header_t number_header(input dri_pkg::target_t tgt, input int nd,
                                                   input int ex, input bit neg,
                                                   input bit spec);
    number_header_t h;
    h.tgt  = tgt;
    h.nd   = 7'(nd);
    h.ex   = 16'(ex);
    h.neg  = neg;
    h.spec = spec;
    return h;
  endfunction

  function automatic number_header_t random_header();
    number_header_t h;
    h.tgt  = dri_pkg::target_t'($urandom_range(0, 3));
    h.nd   = 7'($urandom_range(0, 127));
    h.ex   = 16'($urandom_range(0, 65535));
    h.neg  = 1'($urandom_range(0, 1));
    h.spec = 1'($urandom_range(0, 1));
    return h;
  endfunction

  task automatic send_unit(input logic is_first, input number_header_t h,
                           input logic [9:0] u, input logic is_last);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    push        <= 1'b1;
    first_unit  <= is_first;
    target_kind <= h.tgt;
    digit_count <= h.nd;
    exponent    <= h.ex;
    is_negative <= h.neg;
    is_special  <= h.spec;
    unit_value  <= u;
    last_unit   <= is_last;
    do @(posedge clk); while (full);
    units_sent++;
    predict_unit(is_first, h, u, is_last);
  endtask

  // header fields on continuation units are ignored, so they carry noise
  task automatic send_number(input number_header_t h);
    int i;
    for (i = 0; i < coef_units.size(); i++)
      send_unit(i == 0, (i == 0) ? h : random_header(), coef_units[i],
                i == coef_units.size() - 1);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (pending_ints.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_number();
    number_header_t h;
    int d, w0, n, pick, i;
    h = random_header();
    pick = $urandom_range(0, 99);
    if (pick < 75) h.nd = 7'($urandom_range(1, 20));
    else if (pick < 90) h.nd = 7'($urandom_range(21, 75));
    d = digits_in_use(h.nd);
    pick = $urandom_range(0, 99);
    // mostly exponents that leave a few integer digits
    if (pick < 70) h.ex = 16'(int'($urandom_range(0, 24)) - (d + 3));
    else if (pick < 85) h.ex = 16'(int'($urandom_range(0, 200)) - 100);
    h.spec = ($urandom_range(0, 9) == 0);
    n = (d + 2) / 3;
    w0 = ((d - 1) % 3) + 1;
    pick = $urandom_range(0, 99);
    if (pick < 8 && n > 1) n = $urandom_range(1, n - 1);
    else if (pick >= 95) n += $urandom_range(1, 3);
    coef_units.delete();
    for (i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(0, 9) != 0)
        coef_units.push_back(10'($urandom_range(0, int'(pow10(w0)) - 1)));
      else
        coef_units.push_back(10'($urandom_range(0, 999)));
    end
    send_number(h);
  endtask

  task automatic test_headerless_unit();
    // saved header is all zero after reset: one digit, signed 32
    send_unit(1'b0, random_header(), 10'd999, 1'b1);
  endtask

  task automatic test_range_limits();
    coef_units = '{10'd0};
    send_number(number_header(dri_pkg::TGT_S32, 1, 0, 1'b0, 1'b0));
    coef_units = '{10'd2, 10'd147, 10'd483, 10'd647};
    send_number(number_header(dri_pkg::TGT_S32, 10, 0, 1'b0, 1'b0));
    coef_units = '{10'd2, 10'd147, 10'd483, 10'd648};
    send_number(number_header(dri_pkg::TGT_S32, 10, 0, 1'b1, 1'b0));
    coef_units = '{10'd18, 10'd446, 10'd744, 10'd73, 10'd709, 10'd551, 10'd615};
    send_number(number_header(dri_pkg::TGT_U64, 20, 0, 1'b0, 1'b0));
    coef_units = '{10'd5};
    send_number(number_header(dri_pkg::TGT_U64, 1, 32767, 1'b0, 1'b0));
    coef_units = '{10'd12};
    send_number(number_header(dri_pkg::TGT_S64, 2, -32768, 1'b1, 1'b0));
  endtask

  task automatic test_special_cases();
    coef_units = '{10'd123};
    send_number(number_header(dri_pkg::TGT_S64, 3, 0, 1'b0, 1'b1));
    coef_units = '{10'd7};
    send_number(number_header(dri_pkg::TGT_U32, 0, 0, 1'b0, 1'b0));
    // digit count clamps to the maximum, and the missing units read as zeros
    coef_units = '{10'd999};
    send_number(number_header(dri_pkg::TGT_U64, 127, 0, 1'b0, 1'b0));
    coef_units = '{10'd999};
    send_number(number_header(dri_pkg::TGT_S64, 3, -1, 1'b1, 1'b0));
    coef_units = '{10'd7, 10'd8};
    send_number(number_header(dri_pkg::TGT_S32, 1, 0, 1'b0, 1'b0));
    coef_units = '{10'd5};
    send_number(number_header(dri_pkg::TGT_U32, 1, 0, 1'b1, 1'b0));
  endtask

  task automatic test_input_stall();
    int i;
    tx_idle_on = 1'b0;
    rx_hold_cycles = 80;
    for (i = 0; i < 24; i++) begin
      coef_units = '{10'($urandom_range(0, 999))};
      send_number(number_header(dri_pkg::target_t'($urandom_range(0, 3)),
                                $urandom_range(1, 3), 0, $urandom_range(0, 1), 1'b0));
    end
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_numbers(input int count);
    int start, pick;
    start = units_sent;
    while (units_sent - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        send_unit(1'($urandom_range(0, 1)), random_header(), 10'($urandom_range(0, 999)),
                  1'($urandom_range(0, 1)));
      else if (pick < 6)
        wait_drained();
      else
        send_random_number();
    end
  endtask

  task automatic test_streaming();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_numbers(60);
  endtask

  // receiver: random stalls, plus a long hold requested by the stall test
  initial begin : receiver
    int stall;
    stall = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (rx_hold_cycles > 0) begin
        pop <= 1'b0;
        rx_hold_cycles--;
      end else if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 3);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && push && full) full_cycles++;
    if (!rst && pop && !empty) begin
      if (pending_ints.size() == 0) begin
        $error("unexpected result transfer: result_bits %h overflow %b", result_bits, overflow);
        errors++;
      end else begin
        head_int = pending_ints.pop_front();
        if (result_bits !== head_int.bits) begin
          $error("result_bits mismatch: expected %h, actual %h", head_int.bits, result_bits);
          errors++;
        end
        if (overflow !== head_int.ovf) begin
          $error("overflow mismatch: expected %b, actual %b", head_int.ovf, overflow);
          errors++;
        end
        if (overflow === 1'b1) ovf_results++;
        results_checked++;
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    push        <= 1'b0;
    first_unit  <= 1'b0;
    target_kind <= '0;
    digit_count <= '0;
    exponent    <= '0;
    is_negative <= 1'b0;
    is_special  <= 1'b0;
    unit_value  <= '0;
    last_unit   <= 1'b0;
    conv_acc    = '0;
    conv_done   = 0;
    conv_ovf    = 1'b0;
    hdr_target  = dri_pkg::TGT_S32;
    hdr_digits  = '0;
    hdr_exp     = '0;
    hdr_neg     = 1'b0;
    hdr_special = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_headerless_unit();
    test_range_limits();
    test_special_cases();
    wait_drained();
    test_input_stall();
    test_random_numbers(350);
    test_streaming();

    wait_drained();
    repeat (150) @(posedge clk);
    $display("Checked %0d conversions from %0d units over all four targets, %0d with overflow",
             results_checked, units_sent, ovf_results);
    $display("Included specials, clamped and partial numbers, header-less units, %0d stall cycles",
             full_cycles);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
